>>> hdl/wrs_pkg.sv
// ----------------------------------------------------------------------------
// wrs_pkg: shared types and tables for the word replacement core
// Opcodes, status codes, controller states and the suffix tables used for
// stemming and suffix reattachment.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wrs_pkg;

  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_LOOK = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_REJ   = 2'd1;
  localparam logic [1:0] ST_FOUND = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_FOUND,
    S_WRITE,
    S_MOVE,
    S_CAPTURE,
    S_STEM,
    S_CHECK,
    S_PREP,
    S_EM_RD,
    S_EM_WR,
    S_SINGLE
  } state_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_vowel(input logic [7:0] c);
    return c == "a" || c == "e" || c == "i" || c == "o" || c == "u" || c == "y";
  endfunction

  function automatic logic suf_dbl(input logic [3:0] i);
    return i == 4'd4 || i == 4'd7;
  endfunction

  function automatic logic [7:0] suf_drop(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd2, 4'd9: c = "y";
      4'd5:       c = "e";
      default:    c = " ";
    endcase
    return c;
  endfunction

  function automatic logic [1:0] suf_len(input logic [3:0] i);
    logic [1:0] n;
    case (i)
      4'd0, 4'd6:               n = 2'd1;
      4'd1, 4'd7, 4'd8, 4'd10:  n = 2'd2;
      4'd2, 4'd3, 4'd4, 4'd5,
      4'd9, 4'd11:              n = 2'd3;
      default:                  n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] suf_char(input logic [3:0] i, input logic [1:0] p);
    logic [23:0] s;
    case (i)
      4'd0:             s = "s  ";
      4'd1:             s = "es ";
      4'd2:             s = "ies";
      4'd3, 4'd4, 4'd5: s = "ing";
      4'd6:             s = "d  ";
      4'd7, 4'd8:       s = "ed ";
      4'd9:             s = "ied";
      4'd10:            s = "'s ";
      4'd11:            s = "'ll";
      default:          s = "   ";
    endcase
    return (p == 2'd0) ? s[23:16] : ((p == 2'd1) ? s[15:8] : s[7:0]);
  endfunction

endpackage

`default_nettype wire

>>> hdl/wrs_cell.sv
// ----------------------------------------------------------------------------
// wrs_cell: one byte cell of a buffer chain
// Holds one character; loads a new one or takes its neighbor's on a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wrs_cell (
  input  wire logic       clk,
  input  wire logic       load,
  input  wire logic [7:0] load_data,
  input  wire logic       shift,
  input  wire logic [7:0] shift_in,
  output logic [7:0]      q
);

  logic [7:0] q_r;
  logic [7:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (load) begin
      q_nxt = load_data;
    end else if (shift) begin
      q_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

>>> hdl/wrs_chain.sv
// ----------------------------------------------------------------------------
// wrs_chain: circular row of byte cells
// Bytes are written by position; a rotate moves every byte one cell toward
// the head, so N rotates walk the whole string past the head and realign it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wrs_chain #(
  parameter int N = 32
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [$clog2(N)-1:0] wr_idx,
  input  wire logic [7:0]           wr_data,
  input  wire logic                 rot,
  output logic [7:0]                head
);

  logic [7:0] q [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    wrs_cell u_cell (
      .clk       (clk),
      .load      (wr_en && (wr_idx == ($clog2(N))'(i))),
      .load_data (wr_data),
      .shift     (rot),
      .shift_in  (q[(i + 1) % N]),
      .q         (q[i])
    );
  end

  assign head = q[0];

endmodule

`default_nettype wire

>>> hdl/word_replace_with_suffix_stemming_core.sv
// ----------------------------------------------------------------------------
// word_replace_with_suffix_stemming_core: replacement dictionary with stemming
// Set, delete and look up of letter keys; failed lookups strip an English
// suffix, look up the root and put the suffix back on the replacement.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | in_opcode in_part in_char_byte in_char_valid in_last
//  out     | out_valid/out_stall| out_status out_out_byte out_out_valid out_out_last
//
// A beat that does not end a command keeps the core idle. A command end walks
// the stored entries through the key memory, byte by byte against the word
// chain; a stemmed lookup adds a capture pass and a second walk. Set copies
// the chains into an entry, delete may move the last entry into the freed slot,
// and each output character takes a memory read state, then an output register.
// Reset clears the controller state, entry count, output valid and buffer state only; no clearing pass.
// Input stalls while a command is processed; output stall holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module word_replace_with_suffix_stemming_core #(
  parameter int WORD_LEN  = 32,
  parameter int NUM_WORDS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_opcode,
  input  wire logic       in_part,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_char_valid,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_status,
  output logic [7:0]      out_out_byte,
  output logic            out_out_valid,
  output logic            out_out_last
);
  import wrs_pkg::*;

  localparam int CW   = $clog2(WORD_LEN + 1);
  localparam int IW   = $clog2(WORD_LEN);
  localparam int TW   = $clog2(WORD_LEN + 6);
  localparam int CNTW = $clog2(NUM_WORDS + 1);
  localparam int JW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int AW   = $clog2(NUM_WORDS * WORD_LEN);
  localparam int DEPTH = NUM_WORDS * WORD_LEN;

  // memories
  logic [7:0]    key_mem  [DEPTH];
  logic [7:0]    repl_mem [DEPTH];
  logic [CW-1:0] klen_mem [NUM_WORDS];
  logic [CW-1:0] rlen_mem [NUM_WORDS];
  logic [7:0]    key_q, repl_q;
  logic [CW-1:0] klen_q, rlen_q;

  state_t state_r, state_nxt;
  logic [1:0]      op_r, op_nxt;
  logic            stem_r, stem_nxt;
  logic [CW-1:0]   kl_r, kl_nxt, rl_r, rl_nxt;
  logic            kbad_r, kbad_nxt, klong_r, klong_nxt, rlong_r, rlong_nxt;
  logic [CW-1:0]   klat_r, klat_nxt, rlat_r, rlat_nxt;
  logic [CW-1:0]   tlen_r, tlen_nxt;
  logic            sub_en_r, sub_en_nxt;
  logic [CW-1:0]   sub_pos_r, sub_pos_nxt;
  logic [7:0]      sub_chr_r, sub_chr_nxt;
  logic [CNTW-1:0] jj_r, jj_nxt, cnt_r, cnt_nxt;
  logic [CW-1:0]   ix_r, ix_nxt;
  logic            match_r, match_nxt, found_r, found_nxt, new_r, new_nxt;
  logic [JW-1:0]   fj_r, fj_nxt, src_r, src_nxt;
  logic [7:0]      cap_r [6];
  logic [7:0]      cap_nxt [6];
  logic [3:0]      sidx_r, sidx_nxt;
  logic            bad_r, bad_nxt;
  logic [7:0]      lastc_r, lastc_nxt;
  logic [CW-1:0]   nrep_r, nrep_nxt;
  logic            extra_r, extra_nxt;
  logic [TW-1:0]   total_r, total_nxt, k_r, k_nxt;
  logic [1:0]      sgl_r, sgl_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_st_r, out_st_nxt;
  logic [7:0]      out_b_r, out_b_nxt;
  logic            out_v_r, out_v_nxt, out_l_r, out_l_nxt;

  // input beat decode
  logic          kap, rap, k_room, r_room, out_free;
  logic [7:0]    ch_lc;
  logic [CW-1:0] kl_n, rl_n, ixm1;
  logic          kbad_n, klong_n, rlong_n;

  assign kap    = in_char_valid && !in_part;
  assign rap    = in_char_valid && in_part;
  assign k_room = kl_r < CW'(WORD_LEN);
  assign r_room = rl_r < CW'(WORD_LEN);
  assign ch_lc  = (in_char_byte >= "A" && in_char_byte <= "Z") ?
                  in_char_byte + 8'd32 : in_char_byte;
  assign kl_n    = kl_r + CW'(kap && k_room);
  assign rl_n    = rl_r + CW'(rap && r_room);
  assign kbad_n  = kbad_r || (kap && !is_letter(in_char_byte));
  assign klong_n = klong_r || (kap && !k_room);
  assign rlong_n = rlong_r || (rap && !r_room);
  assign ixm1    = ix_r - CW'(1);
  assign out_free = !out_valid_r || !out_stall;

  // buffer chains
  logic       w_wr, s_wr, w_rot, s_rot;
  logic [7:0] w_head, s_head;

  wrs_chain #(.N(WORD_LEN)) u_word (
    .clk (clk), .wr_en (w_wr), .wr_idx (kl_r[IW-1:0]), .wr_data (ch_lc),
    .rot (w_rot), .head (w_head)
  );

  wrs_chain #(.N(WORD_LEN)) u_second (
    .clk (clk), .wr_en (s_wr), .wr_idx (rl_r[IW-1:0]), .wr_data (in_char_byte),
    .rot (s_rot), .head (s_head)
  );

  // memory addressing
  logic [JW-1:0] ra_ent, len_ra;
  logic [IW-1:0] ra_off, wa_off;
  logic [AW-1:0] ra, wa;
  logic          kw_en, rw_en, klw_en, rlw_en;
  logic [7:0]    kw_dat, rw_dat;
  logic [CW-1:0] klw_dat, rlw_dat;

  assign ra_ent = (state_r == S_SEARCH) ? jj_r[JW-1:0] :
                  ((state_r == S_MOVE) ? src_r : fj_r);
  assign len_ra = ra_ent;
  assign ra_off = (state_r == S_EM_RD || state_r == S_EM_WR) ? k_r[IW-1:0] : ix_r[IW-1:0];
  assign wa_off = (state_r == S_MOVE) ? ixm1[IW-1:0] : ix_r[IW-1:0];
  assign ra = AW'(AW'(ra_ent) * AW'(WORD_LEN)) + AW'(ra_off);
  assign wa = AW'(AW'(fj_r) * AW'(WORD_LEN)) + AW'(wa_off);

  always_ff @(posedge clk) begin
    if (kw_en) key_mem[wa] <= kw_dat;
    if (rw_en) repl_mem[wa] <= rw_dat;
    if (klw_en) klen_mem[fj_r] <= klw_dat;
    if (rlw_en) rlen_mem[fj_r] <= rlw_dat;
    key_q  <= key_mem[ra];
    repl_q <= repl_mem[ra];
    klen_q <= klen_mem[len_ra];
    rlen_q <= rlen_mem[len_ra];
  end

  // suffix stripping on the captured tail: cap 0 is the byte before the
  // last five letters
  logic          st_ok, st_sub;
  logic [3:0]    st_idx;
  logic [CW-1:0] st_rlen;
  logic [7:0]    st_chr;

  always_comb begin
    st_ok   = 1'b0;
    st_sub  = 1'b0;
    st_idx  = 4'd0;
    st_rlen = klat_r;
    st_chr  = "y";
    if (cap_r[5] == "s") begin
      if (!(cap_r[4] inside {"s", "i", "a", "u"})) begin
        st_ok = 1'b1;
        if (cap_r[4] == "e" && cap_r[3] == "i") begin
          st_idx = 4'd2; st_rlen = klat_r - CW'(2); st_sub = 1'b1;
        end else if (cap_r[4] == "e" && (cap_r[3] inside {"s", "h", "z"})) begin
          st_idx = 4'd1; st_rlen = klat_r - CW'(2);
        end else begin
          st_idx = 4'd0; st_rlen = klat_r - CW'(1);
        end
      end
    end else if (klat_r != CW'(5)) begin
      if (cap_r[5] == "g" && cap_r[4] == "n" && cap_r[3] == "i") begin
        st_ok = 1'b1;
        if (!is_vowel(cap_r[2]) && cap_r[2] == cap_r[1]) begin
          st_idx = 4'd4; st_rlen = klat_r - CW'(4);
        end else if (!is_vowel(cap_r[2]) && is_vowel(cap_r[1]) && cap_r[1] < "w" &&
                     !is_vowel(cap_r[0])) begin
          st_idx = 4'd5; st_rlen = klat_r - CW'(2); st_sub = 1'b1; st_chr = "e";
        end else begin
          st_idx = 4'd3; st_rlen = klat_r - CW'(3);
        end
      end else if (cap_r[5] == "d" && cap_r[4] == "e") begin
        st_ok = 1'b1;
        if (cap_r[3] == "i") begin
          st_idx = 4'd9; st_rlen = klat_r - CW'(2); st_sub = 1'b1;
        end else if (!is_vowel(cap_r[3]) && cap_r[3] == cap_r[2]) begin
          st_idx = 4'd7; st_rlen = klat_r - CW'(3);
        end else if (!is_vowel(cap_r[3]) && is_vowel(cap_r[2]) && cap_r[2] < "w" &&
                     !is_vowel(cap_r[1])) begin
          st_idx = 4'd6; st_rlen = klat_r - CW'(1);
        end else begin
          st_idx = 4'd8; st_rlen = klat_r - CW'(2);
        end
      end
    end
  end

  // controller
  logic       cmp_ok, dbl, drp;
  logic [7:0] exp_c;
  logic [TW-1:0] sfx_pos;

  always_comb begin
    state_nxt = state_r;   op_nxt = op_r;       stem_nxt = stem_r;
    kl_nxt = kl_r;         rl_nxt = rl_r;       kbad_nxt = kbad_r;
    klong_nxt = klong_r;   rlong_nxt = rlong_r; klat_nxt = klat_r;
    rlat_nxt = rlat_r;     tlen_nxt = tlen_r;   sub_en_nxt = sub_en_r;
    sub_pos_nxt = sub_pos_r; sub_chr_nxt = sub_chr_r;
    jj_nxt = jj_r;         cnt_nxt = cnt_r;     ix_nxt = ix_r;
    match_nxt = match_r;   found_nxt = found_r; new_nxt = new_r;
    fj_nxt = fj_r;         src_nxt = src_r;     sidx_nxt = sidx_r;
    bad_nxt = bad_r;       lastc_nxt = lastc_r; nrep_nxt = nrep_r;
    extra_nxt = extra_r;   total_nxt = total_r; k_nxt = k_r;
    sgl_nxt = sgl_r;
    for (int c = 0; c < 6; c++) cap_nxt[c] = cap_r[c];
    out_valid_nxt = out_valid_r && out_stall;
    out_st_nxt = out_st_r; out_b_nxt = out_b_r; out_v_nxt = out_v_r; out_l_nxt = out_l_r;
    w_wr = 1'b0; s_wr = 1'b0; w_rot = 1'b0; s_rot = 1'b0;
    kw_en = 1'b0; rw_en = 1'b0; klw_en = 1'b0; rlw_en = 1'b0;
    kw_dat = w_head; rw_dat = s_head; klw_dat = klat_r; rlw_dat = rlat_r;
    exp_c = (sub_en_r && ixm1 == sub_pos_r) ? sub_chr_r : w_head;
    cmp_ok = (ixm1 >= tlen_r) || (key_q == exp_c);
    dbl = suf_dbl(sidx_r) && (rlen_q != '0);
    drp = (rlen_q != '0) && (lastc_r == suf_drop(sidx_r));
    sfx_pos = k_r - TW'(nrep_r) - TW'(extra_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          w_wr = kap && k_room;
          s_wr = rap && r_room;
          if (!in_last) begin
            kl_nxt = kl_n; rl_nxt = rl_n;
            kbad_nxt = kbad_n; klong_nxt = klong_n; rlong_nxt = rlong_n;
          end else begin
            kl_nxt = '0; rl_nxt = '0;
            kbad_nxt = 1'b0; klong_nxt = 1'b0; rlong_nxt = 1'b0;
            klat_nxt = kl_n; rlat_nxt = rl_n; tlen_nxt = kl_n;
            op_nxt = in_opcode; stem_nxt = 1'b0; sub_en_nxt = 1'b0;
            jj_nxt = '0; ix_nxt = '0; match_nxt = 1'b1;
            state_nxt = S_SEARCH;
            case (in_opcode)
              OP_LOOK: begin
                if (kbad_n || klong_n) begin
                  sgl_nxt = ST_NONE; state_nxt = S_SINGLE;
                end
              end
              OP_SET: begin
                if (kbad_n || klong_n || rlong_n) begin
                  sgl_nxt = ST_REJ; state_nxt = S_SINGLE;
                end
              end
              OP_DEL: begin
                if (kbad_n || klong_n) begin
                  sgl_nxt = ST_REJ; state_nxt = S_SINGLE;
                end
              end
              default: begin
                sgl_nxt = ST_REJ; state_nxt = S_SINGLE;
              end
            endcase
          end
        end
      end
      S_SEARCH: begin
        if (jj_r == cnt_r) begin
          found_nxt = 1'b0; state_nxt = S_FOUND;
        end else if (ix_r == '0) begin
          ix_nxt = CW'(1);
        end else begin
          w_rot = 1'b1;
          if (ix_r == CW'(WORD_LEN)) begin
            if (match_r && cmp_ok && klen_q == tlen_r) begin
              found_nxt = 1'b1; fj_nxt = jj_r[JW-1:0]; state_nxt = S_FOUND;
            end else begin
              jj_nxt = jj_r + CNTW'(1); ix_nxt = '0; match_nxt = 1'b1;
            end
          end else begin
            match_nxt = match_r && cmp_ok;
            ix_nxt = ix_r + CW'(1);
          end
        end
      end
      S_FOUND: begin
        ix_nxt = '0;
        sgl_nxt = ST_DONE;
        state_nxt = S_SINGLE;
        case (op_r)
          OP_SET: begin
            if (found_r) begin
              new_nxt = 1'b0; state_nxt = S_WRITE;
            end else if (cnt_r == CNTW'(NUM_WORDS)) begin
              sgl_nxt = ST_REJ;
            end else begin
              new_nxt = 1'b1; fj_nxt = cnt_r[JW-1:0];
              cnt_nxt = cnt_r + CNTW'(1); state_nxt = S_WRITE;
            end
          end
          OP_DEL: begin
            if (found_r) begin
              cnt_nxt = cnt_r - CNTW'(1);
              src_nxt = JW'(cnt_r - CNTW'(1));
              // last entry moves into the freed slot
              if (fj_r != JW'(cnt_r - CNTW'(1))) state_nxt = S_MOVE;
            end
          end
          default: begin
            if (!stem_r) begin
              if (found_r) begin
                state_nxt = S_PREP;
              end else if (klat_r < CW'(5)) begin
                sgl_nxt = ST_NONE;
              end else begin
                state_nxt = S_CAPTURE;
              end
            end else if (found_r) begin
              bad_nxt = 1'b0; state_nxt = S_CHECK;
            end else begin
              sgl_nxt = ST_NONE;
            end
          end
        endcase
      end
      S_WRITE: begin
        w_rot = 1'b1; s_rot = 1'b1;
        kw_en = new_r; rw_en = 1'b1;
        klw_en = new_r && (ix_r == '0); rlw_en = (ix_r == '0);
        ix_nxt = ix_r + CW'(1);
        if (ix_r == CW'(WORD_LEN - 1)) begin
          sgl_nxt = ST_DONE; state_nxt = S_SINGLE;
        end
      end
      S_MOVE: begin
        kw_dat = key_q; rw_dat = repl_q; klw_dat = klen_q; rlw_dat = rlen_q;
        kw_en = (ix_r != '0); rw_en = (ix_r != '0);
        klw_en = (ix_r == CW'(1)); rlw_en = (ix_r == CW'(1));
        ix_nxt = ix_r + CW'(1);
        if (ix_r == CW'(WORD_LEN)) begin
          sgl_nxt = ST_DONE; state_nxt = S_SINGLE;
        end
      end
      S_CAPTURE: begin
        w_rot = 1'b1;
        for (int c = 0; c < 6; c++) begin
          if (TW'(ix_r) + TW'(6) == TW'(klat_r) + TW'(c)) cap_nxt[c] = w_head;
        end
        ix_nxt = ix_r + CW'(1);
        if (ix_r == CW'(WORD_LEN - 1)) state_nxt = S_STEM;
      end
      S_STEM: begin
        if (!st_ok) begin
          sgl_nxt = ST_NONE; state_nxt = S_SINGLE;
        end else begin
          sidx_nxt = st_idx; tlen_nxt = st_rlen; sub_en_nxt = st_sub;
          sub_pos_nxt = klat_r - CW'(3); sub_chr_nxt = st_chr;
          stem_nxt = 1'b1; jj_nxt = '0; ix_nxt = '0; match_nxt = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_CHECK: begin
        if (ix_r != '0) begin
          lastc_nxt = repl_q;
          bad_nxt = bad_r || !(is_letter(repl_q) || repl_q == " ");
        end
        ix_nxt = ix_r + CW'(1);
        if (ix_r == rlen_q) begin
          if (bad_nxt) begin
            sgl_nxt = ST_NONE; state_nxt = S_SINGLE;
          end else begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        k_nxt = '0;
        if (!stem_r) begin
          nrep_nxt = rlen_q; extra_nxt = 1'b0;
          total_nxt = TW'(rlen_q);
        end else begin
          nrep_nxt = rlen_q - CW'(drp && !dbl);
          extra_nxt = dbl && !drp;
          total_nxt = TW'(rlen_q - CW'(drp && !dbl)) + TW'(dbl && !drp) +
                      TW'(suf_len(sidx_r));
        end
        if (!stem_r && rlen_q == '0) begin
          sgl_nxt = ST_FOUND; state_nxt = S_SINGLE;
        end else begin
          state_nxt = S_EM_RD;
        end
      end
      S_EM_RD: begin
        state_nxt = S_EM_WR;
      end
      S_EM_WR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt = ST_FOUND; out_v_nxt = 1'b1;
          out_l_nxt = (k_r == total_r - TW'(1));
          if (k_r < TW'(nrep_r)) out_b_nxt = repl_q;
          else if (extra_r && k_r == TW'(nrep_r)) out_b_nxt = lastc_r;
          else out_b_nxt = suf_char(sidx_r, sfx_pos[1:0]);
          k_nxt = k_r + TW'(1);
          state_nxt = (k_r == total_r - TW'(1)) ? S_IDLE : S_EM_RD;
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt = sgl_r; out_b_nxt = 8'd0; out_v_nxt = 1'b0; out_l_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      kl_r <= '0; rl_r <= '0;
      kbad_r <= 1'b0; klong_r <= 1'b0; rlong_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      kl_r <= kl_nxt; rl_r <= rl_nxt;
      kbad_r <= kbad_nxt; klong_r <= klong_nxt; rlong_r <= rlong_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;       stem_r <= stem_nxt;     klat_r <= klat_nxt;
    rlat_r <= rlat_nxt;   tlen_r <= tlen_nxt;     sub_en_r <= sub_en_nxt;
    sub_pos_r <= sub_pos_nxt; sub_chr_r <= sub_chr_nxt;
    jj_r <= jj_nxt;       ix_r <= ix_nxt;         match_r <= match_nxt;
    found_r <= found_nxt; new_r <= new_nxt;       fj_r <= fj_nxt;
    src_r <= src_nxt;     sidx_r <= sidx_nxt;     bad_r <= bad_nxt;
    lastc_r <= lastc_nxt; nrep_r <= nrep_nxt;     extra_r <= extra_nxt;
    total_r <= total_nxt; k_r <= k_nxt;           sgl_r <= sgl_nxt;
    for (int c = 0; c < 6; c++) cap_r[c] <= cap_nxt[c];
    out_st_r <= out_st_nxt; out_b_r <= out_b_nxt;
    out_v_r <= out_v_nxt;   out_l_r <= out_l_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_st_r;
  assign out_out_byte  = out_b_r;
  assign out_out_valid = out_v_r;
  assign out_out_last  = out_l_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(NUM_WORDS))
    else $error("entry count above table size");
  a_search_ix: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> ix_r <= CW'(WORD_LEN))
    else $error("search byte index out of range");
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> in_stall)
    else $error("command end did not start processing");
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EM_WR && out_free) |=> out_valid)
    else $error("emitted character not presented");
`endif

endmodule

`default_nettype wire

>>> tb/word_replace_with_suffix_stemming_core_tb.sv
// ----------------------------------------------------------------------------
// word_replace_with_suffix_stemming_core_tb: dictionary and stemming check
// Sends set, delete, lookup and unused-opcode commands as byte beats with bursty input and
// patterned output stalls. An in-bench dictionary model predicts every
// result beat, and each beat that arrives is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module word_replace_with_suffix_stemming_core_tb;
  import wrs_pkg::*;

  localparam int WLEN    = 32;
  localparam int NWORDS  = 64;
  localparam int IDLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 260;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic       part;
    logic [7:0] chr;
    logic       chr_vld;
    logic       last;
  } cmd_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] chr;
    logic       chr_vld;
    logic       last;
  } reply_beat_t;

  typedef logic [7:0] str_t [$];

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_opcode;
  logic in_part, in_char_valid, in_last;
  logic [7:0] in_char_byte;
  logic out_valid, out_stall;
  logic [1:0] out_status;
  logic [7:0] out_out_byte;
  logic out_out_valid, out_out_last;

  word_replace_with_suffix_stemming_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_part(in_part), .in_char_byte(in_char_byte),
    .in_char_valid(in_char_valid), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_out_byte(out_out_byte),
    .out_out_valid(out_out_valid), .out_out_last(out_out_last)
  );

  // dictionary model state
  str_t dict_keys [NWORDS];
  str_t dict_repls [NWORDS];
  int   dict_count;
  str_t key_acc, repl_acc;
  bit   key_long, key_bad, repl_long;

  cmd_beat_t   cmd_queue [$];
  reply_beat_t reply_queue [$];
  int   err_count;
  int   idle_cycles;
  bit   stim_done;
  bit   hold_off;
  bit   in_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit letter_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit vowel_c(logic [7:0] c);
    return c == "a" || c == "e" || c == "i" || c == "o" || c == "u" || c == "y";
  endfunction

  function automatic int find_entry(str_t w);
    for (int i = 0; i < dict_count; i++)
      if (dict_keys[i] == w) return i;
    return -1;
  endfunction

  function automatic void push_reply(logic [1:0] st, logic [7:0] c, bit v, bit l);
    reply_beat_t r;
    r.status = st; r.chr = c; r.chr_vld = v; r.last = l;
    reply_queue.push_back(r);
  endfunction

  function automatic void push_string(str_t s);
    if (s.size() == 0) push_reply(ST_FOUND, 8'd0, 1'b0, 1'b1);
    foreach (s[i]) push_reply(ST_FOUND, s[i], 1'b1, i == s.size() - 1);
  endfunction

  // returns suffix index 0..9, or -1 when nothing strips
  function automatic int strip_word(str_t w, output str_t root);
    int n, l;
    logic [7:0] c0, c1, c2, c3, c4;
    root = w;
    n = w.size();
    if (n < 5) return -1;
    l = n - 5;
    c0 = w[l]; c1 = w[l+1]; c2 = w[l+2]; c3 = w[l+3]; c4 = w[l+4];
    if (c4 == "s") begin
      if (c3 == "s" || c3 == "i" || c3 == "a" || c3 == "u") return -1;
      if (c3 == "e") begin
        if (c2 == "i") begin
          root[l+2] = "y"; root = root[0:l+2]; return 2;
        end
        if (c2 == "s" || c2 == "h" || c2 == "z") begin
          root = root[0:l+2]; return 1;
        end
      end
      root = root[0:l+3];
      return 0;
    end
    if (l == 0) return -1;
    if (c4 == "g") begin
      if (c3 != "n" || c2 != "i") return -1;
      if (!vowel_c(c1)) begin
        if (c1 == c0) begin
          root = root[0:l]; return 4;
        end
        if (vowel_c(c0) && c0 < "w" && !vowel_c(w[l-1])) begin
          root[l+2] = "e"; root = root[0:l+2]; return 5;
        end
      end
      root = root[0:l+1];
      return 3;
    end
    if (c4 == "d") begin
      if (c3 != "e") return -1;
      if (c2 == "i") begin
        root[l+2] = "y"; root = root[0:l+2]; return 9;
      end
      if (!vowel_c(c2)) begin
        if (c2 == c1) begin
          root = root[0:l+1]; return 7;
        end
        if (vowel_c(c1) && c1 < "w" && !vowel_c(c0)) begin
          root = root[0:l+3]; return 6;
        end
      end
      root = root[0:l+2];
      return 8;
    end
    return -1;
  endfunction

  function automatic void predict_lookup();
    str_t root, res;
    int j, idx;
    logic [3:0] si;
    j = find_entry(key_acc);
    if (j >= 0) begin
      push_string(dict_repls[j]);
      return;
    end
    idx = strip_word(key_acc, root);
    if (idx < 0) begin
      push_reply(ST_NONE, 8'd0, 1'b0, 1'b1); return;
    end
    j = find_entry(root);
    if (j < 0) begin
      push_reply(ST_NONE, 8'd0, 1'b0, 1'b1); return;
    end
    res = dict_repls[j];
    foreach (res[i])
      if (res[i] != " " && !letter_c(res[i])) begin
        push_reply(ST_NONE, 8'd0, 1'b0, 1'b1); return;
      end
    si = idx[3:0];
    if ((si == 4'd4 || si == 4'd7) && res.size() > 0) res.push_back(res[$]);
    // drop code is a space for plain suffixes, so a trailing space goes too
    if (res.size() > 0 && res[$] == suf_drop(si)) void'(res.pop_back());
    for (int p = 0; p < suf_len(si); p++) res.push_back(suf_char(si, p[1:0]));
    push_string(res);
  endfunction

  function automatic void predict_beat(cmd_beat_t b);
    logic [7:0] c;
    int j;
    c = b.chr;
    if (b.chr_vld) begin
      if (!b.part) begin
        if (!letter_c(c)) key_bad = 1;
        if (c >= "A" && c <= "Z") c = c + 8'd32;
        if (key_acc.size() < WLEN) key_acc.push_back(c);
        else key_long = 1;
      end else begin
        if (repl_acc.size() < WLEN) repl_acc.push_back(c);
        else repl_long = 1;
      end
    end
    if (!b.last) return;
    case (b.opcode)
      OP_LOOK: begin
        if (key_long || key_bad) push_reply(ST_NONE, 8'd0, 1'b0, 1'b1);
        else predict_lookup();
      end
      OP_SET: begin
        if (key_long || key_bad || repl_long) push_reply(ST_REJ, 8'd0, 1'b0, 1'b1);
        else begin
          j = find_entry(key_acc);
          if (j < 0 && dict_count >= NWORDS) push_reply(ST_REJ, 8'd0, 1'b0, 1'b1);
          else begin
            if (j < 0) begin
              j = dict_count++;
              dict_keys[j] = key_acc;
            end
            dict_repls[j] = repl_acc;
            push_reply(ST_DONE, 8'd0, 1'b0, 1'b1);
          end
        end
      end
      OP_DEL: begin
        if (key_long || key_bad) push_reply(ST_REJ, 8'd0, 1'b0, 1'b1);
        else begin
          j = find_entry(key_acc);
          if (j >= 0) begin
            dict_count--;
            dict_keys[j] = dict_keys[dict_count];
            dict_repls[j] = dict_repls[dict_count];
          end
          push_reply(ST_DONE, 8'd0, 1'b0, 1'b1);
        end
      end
      default: push_reply(ST_REJ, 8'd0, 1'b0, 1'b1);
    endcase
    key_acc = {}; repl_acc = {};
    key_long = 0; key_bad = 0; repl_long = 0;
  endfunction

  // ---- stimulus builders
  task automatic send_cmd(logic [1:0] op, str_t k, str_t r);
    cmd_beat_t b;
    int total;
    total = k.size() + r.size();
    if (total == 0) begin
      b = '{opcode: op, part: 1'($urandom), chr: 8'($urandom), chr_vld: 0, last: 1};
      cmd_queue.push_back(b);
      return;
    end
    foreach (k[i]) begin
      b = '{opcode: 2'($urandom), part: 0, chr: k[i], chr_vld: 1, last: 0};
      cmd_queue.push_back(b);
      // occasional empty beat that adds nothing
      if ($urandom_range(0, 15) == 0) begin
        b.chr_vld = 0; b.part = 1'($urandom); b.chr = 8'($urandom);
        cmd_queue.push_back(b);
      end
    end
    foreach (r[i]) begin
      b = '{opcode: 2'($urandom), part: 1, chr: r[i], chr_vld: 1, last: 0};
      cmd_queue.push_back(b);
    end
    cmd_queue[$].opcode = op;
    cmd_queue[$].last = 1;
  endtask

  function automatic str_t rand_word(int lo, int hi, bit upper_ok);
    str_t w;
    int n;
    n = $urandom_range(lo, hi);
    for (int i = 0; i < n; i++) begin
      // small alphabet so roots and suffix patterns collide often
      w.push_back(8'("a") + 8'($urandom_range(0, 7) * 3 % 26));
      if (upper_ok && $urandom_range(0, 9) == 0) w[i] = w[i] - 8'd32;
    end
    return w;
  endfunction

  function automatic str_t cat(str_t a, string s);
    str_t w;
    w = a;
    for (int i = 0; i < s.len(); i++) w.push_back(s[i]);
    return w;
  endfunction

  function automatic str_t to_str(string s);
    str_t w;
    return cat(w, s);
  endfunction

  function automatic str_t rand_repl();
    str_t w;
    int n, m;
    n = $urandom_range(0, 8);
    m = $urandom_range(0, 9);
    for (int i = 0; i < n; i++) begin
      if (m == 0) w.push_back(8'($urandom));
      else if ($urandom_range(0, 6) == 0) w.push_back(" ");
      else w.push_back(8'("a") + 8'($urandom_range(0, 25)));
    end
    return w;
  endfunction

  str_t roots [$];
  string suffixes [12] = '{"s", "es", "ies", "ing", "ting", "ing", "d", "ed", "ded",
                           "ied", "ss", "xed"};

  initial begin
    str_t k, r, empty_s;
    int pick;
    // directed: every opcode, extremes, the stemming cases
    send_cmd(OP_SET, empty_s, empty_s);
    send_cmd(OP_LOOK, empty_s, empty_s);
    send_cmd(OP_SET, to_str("walk"), to_str("stroll "));
    send_cmd(OP_LOOK, to_str("walks"), empty_s);
    send_cmd(OP_LOOK, to_str("WALKING"), empty_s);
    send_cmd(OP_SET, to_str("run"), to_str("jog"));
    send_cmd(OP_LOOK, to_str("running"), empty_s);
    send_cmd(OP_SET, to_str("make"), to_str("craft"));
    send_cmd(OP_LOOK, to_str("making"), empty_s);
    send_cmd(OP_SET, to_str("carry"), to_str("tote y"));
    send_cmd(OP_LOOK, to_str("carries"), empty_s);
    send_cmd(OP_LOOK, to_str("carried"), empty_s);
    send_cmd(OP_SET, to_str("box"), to_str("c1te"));
    send_cmd(OP_LOOK, to_str("boxes"), empty_s);
    send_cmd(OP_SET, to_str("bad1"), to_str("x"));
    send_cmd(OP_UNUSED, to_str("walk"), empty_s);
    send_cmd(OP_DEL, to_str("zzzz"), to_str("ignored"));
    send_cmd(OP_DEL, to_str("walk"), empty_s);
    k = rand_word(33, 34, 0);
    send_cmd(OP_SET, k, empty_s);
    r = rand_word(33, 34, 0);
    send_cmd(OP_SET, to_str("long"), r);
    r = {8'hff, 8'h00, 8'h7f, 8'h80};
    send_cmd(OP_SET, to_str("edge"), r);
    send_cmd(OP_LOOK, to_str("edge"), empty_s);
    // random: mostly root sets and stemmed lookups, some noise
    while (cmd_queue.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 5) begin
        k = rand_word(1, 6, 1);
        roots.push_back(k);
        send_cmd(OP_SET, k, rand_repl());
      end else if (pick < 13 && roots.size() > 0) begin
        k = roots[$urandom_range(0, roots.size() - 1)];
        send_cmd(OP_LOOK, cat(k, suffixes[$urandom_range(0, 11)]), empty_s);
      end else if (pick < 15) begin
        send_cmd(OP_LOOK, rand_word(0, 10, 1), empty_s);
      end else if (pick < 17 && roots.size() > 0) begin
        send_cmd(OP_DEL, roots[$urandom_range(0, roots.size() - 1)], rand_repl());
      end else begin
        k = rand_word(0, 5, 0);
        if ($urandom_range(0, 1)) k.push_back(8'($urandom));
        send_cmd(2'($urandom), k, rand_repl());
      end
    end
    stim_done = 1;
  end

  // ---- driver
  cmd_beat_t cur_beat;
  int burst_left, gap_left;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_taken) begin
        // hold the stalled beat
      end else begin
        in_taken = 0;
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          cur_beat = cmd_queue[0];
          in_valid <= 1'b1;
          in_opcode <= cur_beat.opcode;
          in_part <= cur_beat.part;
          in_char_byte <= cur_beat.chr;
          in_char_valid <= cur_beat.chr_vld;
          in_last <= cur_beat.last;
          if (burst_left > 0) burst_left = burst_left - 1;
          else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- receiver stall pattern, with one long hold-off
  int stall_phase, hold_count, accepted_cmds;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
      hold_count = hold_count + 1;
      if (hold_count >= 3000) hold_off = 0;
    end else begin
      stall_phase = stall_phase + 1;
      if (stall_phase[9:8] == 2'd0) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 3) == 0) || (stall_phase[6:5] == 2'd3);
    end
  end

  // ---- model update and monitor
  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    reply_beat_t want;
    if (rst_n) begin
      idle_cycles = idle_cycles + 1;
      if (in_valid && !in_stall) begin
        predict_beat(cmd_queue.pop_front());
        in_taken = 1;
        idle_cycles = 0;
        if (in_last) begin
          accepted_cmds = accepted_cmds + 1;
          if (accepted_cmds == 12) hold_off = 1;
        end
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (reply_queue.size() == 0) report_mismatch("unexpected beat", out_status, 0);
        else begin
          want = reply_queue.pop_front();
          if (out_status !== want.status) report_mismatch("status", out_status, want.status);
          if (out_out_byte !== want.chr) report_mismatch("byte", out_out_byte, want.chr);
          if (out_out_valid !== want.chr_vld)
            report_mismatch("char valid", out_out_valid, want.chr_vld);
          if (out_out_last !== want.last) report_mismatch("last", out_out_last, want.last);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_opcode = OP_SET; in_part = 1'b0; in_char_byte = 8'd0;
    in_char_valid = 1'b0; in_last = 1'b0; out_stall = 1'b0;
    err_count = 0; idle_cycles = 0; hold_off = 0;
    stall_phase = 0; hold_count = 0; accepted_cmds = 0;
    burst_left = 0; gap_left = 0;
    dict_count = 0; key_long = 0; key_bad = 0; repl_long = 0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    while (!(stim_done && cmd_queue.size() == 0 && reply_queue.size() == 0)
           && idle_cycles < IDLE_LIMIT)
      @(posedge clk);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      repeat (200) @(posedge clk);
      if (err_count == 0 && reply_queue.size() == 0) begin
        $display("Testbench completed without errors");
      end else begin
        $display("Testbench completed WITH ERRORS");
      end
      $finish;
    end
  end

endmodule

>>> filelist.f
hdl/wrs_pkg.sv
hdl/wrs_cell.sv
hdl/wrs_chain.sv
hdl/word_replace_with_suffix_stemming_core.sv
tb/word_replace_with_suffix_stemming_core_tb.sv
